@@ rtl/labu_pkg.sv @@
// Package for the legacy Arabic byte to UTF-16 unit: request types, constants, mapping.
package labu_pkg;

  localparam logic [7:0]  ESC_BYTE    = 8'h04;
  localparam logic [7:0]  ARABIC_HIGH = 8'h06;
  localparam logic [15:0] CODE_CR     = 16'h000D;
  localparam logic [15:0] CODE_LF     = 16'h000A;
  localparam logic [1:0]  MAX_UNITS   = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_last_byte;
  } char_req_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
  } unit_rsp_t;

  localparam logic [7:0] ARABIC_LOW [256] = '{
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
    8'h55,8'h09,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,
    8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,
    8'h18,8'h19,8'h1a,8'h1b,8'h1c,8'h1d,8'h1e,8'h1f,
    8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,
    8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,8'h2e,8'h2f,
    8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
    8'h38,8'h39,8'h3a,8'h3b,8'h3c,8'h3d,8'h3e,8'h3f,
    8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
    8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,
    8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5a,8'h5b,8'h5c,8'h5d,8'h5e,8'h5f,
    8'h60,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,
    8'h68,8'h69,8'h6a,8'h41,8'h6c,8'h6d,8'h6e,8'h6f,
    8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,
    8'h78,8'h79,8'h7a,8'h7b,8'h7c,8'h7d,8'h7e,8'h7f,
    8'h80,8'h27,8'h28,8'h7e,8'h2a,8'h79,8'h2b,8'h2c,
    8'h86,8'h2d,8'h2e,8'h2f,8'h88,8'h30,8'h31,8'h91,
    8'h32,8'h98,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,
    8'h39,8'h3a,8'h41,8'h42,8'ha9,8'haf,8'h44,8'h45,
    8'h46,8'hba,8'h48,8'h26,8'hcc,8'hd2,8'hc1,8'hbe,
    8'h4d,8'h40,8'h50,8'h4e,8'h4f,8'h51,8'h11,8'haf,
    8'h56,8'he1,8'hb2,8'h53,8'h52,8'h4c,8'h24,8'ha3,
    8'h4a,8'hc3,8'hba,8'hbb,8'hbc,8'h70,8'h57,8'h54,
    8'hc0,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'h4b,
    8'h22,8'h23,8'h25,8'hcb,8'h1f,8'h1f,8'h1f,8'h14,
    8'h60,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,
    8'h68,8'h69,8'hda,8'hdb,8'hdc,8'hdd,8'h6a,8'hdf,
    8'he0,8'he1,8'he2,8'he3,8'he4,8'he5,8'h13,8'h12,
    8'h6d,8'he9,8'h1b,8'heb,8'hec,8'h0c,8'h1f,8'hef,
    8'hc7,8'h0d,8'h0e,8'hd4,8'h19,8'h40,8'hf6,8'h01,
    8'h10,8'h6b,8'hfa,8'hfb,8'hfc,8'hfd,8'hfe,8'hff
  };

  function automatic logic [15:0] map_escaped(input logic [7:0] b);
    logic [15:0] u;
    case (b)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: u = {8'h00, b};
      8'h3A: u = 16'h005E;
      8'hCB: u = 16'hFDF2;
      8'hDA: u = 16'h0021;
      8'hDB: u = 16'h007D;
      8'hDC: u = 16'h007B;
      8'hDD: u = 16'h0024;
      8'hDF: u = 16'h002F;
      8'hE0: u = 16'h2026;
      8'hE1: u = 16'h0029;
      8'hE2: u = 16'h0028;
      8'hE3: u = 16'h002A;
      8'hE4: u = 16'h002B;
      8'hE9: u = 16'h003A;
      8'hEB: u = 16'h00D7;
      8'hEC: u = 16'h003D;
      8'hEF: u = 16'h00F7;
      8'hF5: u = 16'h2212;
      8'hF6: u = 16'hFDFA;
      8'hFA: u = 16'h005D;
      8'hFB: u = 16'h005B;
      8'hFC: u = 16'h002E;
      8'hFD: u = 16'h2018;
      8'hFE: u = 16'h2019;
      default: u = {ARABIC_HIGH, ARABIC_LOW[b]};
    endcase
    return u;
  endfunction

  function automatic logic passes_through(input logic [7:0] b);
    return ((b >= 8'h09) && (b <= 8'h0D)) || ((b >= 8'h20) && (b <= 8'hFE));
  endfunction

endpackage

@@ rtl/legacy_arabic_byte_to_utf16_unit.sv @@
// Top level: converts legacy Arabic-script record bytes to UTF-16 code units.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+---------------------------------------
//  request  | char_valid  | char_stall  | char_req : byte_value, is_last_byte
//  result   | unit_valid  | unit_stall  | unit_rsp : code_unit, run_last
//
// One request per cycle while each request yields at most one code unit and
// no result is stalled; the result register sends one code unit per cycle,
// so a multi-unit request holds the request side until its last unit is
// sent (end of record: CR LF burst). Units pass input, then result register.
// Reset clears the input register, the result count and the escape flag.
// A stalled result keeps the input register full; one request waits there.
module legacy_arabic_byte_to_utf16_unit import labu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  char_req_t char_req,
  output logic      unit_valid,
  input  logic      unit_stall,
  output unit_rsp_t unit_rsp
);

  logic        ireg_valid;
  char_req_t   ireg;
  logic        escape_pending;
  logic        escape_pending_next;
  logic [1:0]  count;
  logic [15:0] units [3];

  logic [1:0]  n_units;
  logic [15:0] v [3];
  logic        take;
  logic        load;
  logic        accept;

  always_comb begin
    v[0] = CODE_CR;
    v[1] = CODE_LF;
    v[2] = CODE_LF;
    n_units = 2'd0;
    escape_pending_next = escape_pending;
    if (escape_pending) begin
      v[0] = map_escaped(ireg.byte_value);
      n_units = 2'd1;
      escape_pending_next = 1'b0;
    end else if (!ireg.is_last_byte) begin
      if (passes_through(ireg.byte_value)) begin
        v[0] = {8'h00, ireg.byte_value};
        n_units = 2'd1;
      end else if (ireg.byte_value == ESC_BYTE) begin
        escape_pending_next = 1'b1;
      end
    end
    if (ireg.is_last_byte) begin
      if (n_units == 2'd1) begin
        v[1] = CODE_CR;
        v[2] = CODE_LF;
        n_units = MAX_UNITS;
      end else begin
        n_units = 2'd2;
      end
      escape_pending_next = 1'b0;
    end
  end

  assign unit_valid = (count != 2'd0);
  assign take       = unit_valid && !unit_stall;
  assign load       = ireg_valid && ((count == 2'd0) || ((count == 2'd1) && take));
  assign char_stall = ireg_valid && !load;
  assign accept     = char_valid && !char_stall;

  assign unit_rsp.code_unit = units[0];
  assign unit_rsp.run_last  = (count == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid     <= 1'b0;
      count          <= 2'd0;
      escape_pending <= 1'b0;
    end else begin
      if (accept) begin
        ireg_valid <= 1'b1;
      end else if (load) begin
        ireg_valid <= 1'b0;
      end
      if (load) begin
        count          <= n_units;
        escape_pending <= escape_pending_next;
      end else if (take) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ireg <= char_req;
    end
    if (load) begin
      units[0] <= v[0];
      units[1] <= v[1];
      units[2] <= v[2];
    end else if (take) begin
      units[0] <= units[1];
      units[1] <= units[2];
    end
  end

  a_idle_no_stall: assert property (@(posedge clk) disable iff (rst)
    !ireg_valid |-> !char_stall)
    else $error("request stalled with empty input register");

  a_last_clears_escape: assert property (@(posedge clk) disable iff (rst)
    (load && ireg.is_last_byte) |=> !escape_pending)
    else $error("escape flag survived end of record");

  a_last_gives_crlf: assert property (@(posedge clk) disable iff (rst)
    (load && ireg.is_last_byte) |=> (unit_valid && (count >= 2'd2)))
    else $error("end of record without CR LF");

endmodule
